@@ rtl/evc_pkg.sv @@
// Package for the exception vector classifier: vector numbers, frame format
// codes, the result record and the decode functions. No dependencies.
`timescale 1ns / 1ps

package evc_pkg;

    localparam int VectorWidth = 8;
    localparam int OffsetWidth = 10;
    localparam int GroupWidth  = 3;
    localparam int RankWidth   = 2;
    localparam int FormatWidth = 4;
    localparam int LengthWidth = 6;
    localparam int FmtWordWidth = 16;
    localparam int OffsetFieldWidth = 12;

    localparam int InDataWidth  = 8;
    localparam int OutDataWidth = 48;

    localparam logic [7:0] VEC_RESET_SSP   = 8'd0;
    localparam logic [7:0] VEC_RESET_PC    = 8'd1;
    localparam logic [7:0] VEC_BUS_ERROR   = 8'd2;
    localparam logic [7:0] VEC_ADDR_ERROR  = 8'd3;
    localparam logic [7:0] VEC_ILLEGAL     = 8'd4;
    localparam logic [7:0] VEC_ZERO_DIV    = 8'd5;
    localparam logic [7:0] VEC_CHK         = 8'd6;
    localparam logic [7:0] VEC_TRAPCC      = 8'd7;
    localparam logic [7:0] VEC_PRIVILEGE   = 8'd8;
    localparam logic [7:0] VEC_TRACE       = 8'd9;
    localparam logic [7:0] VEC_LINE_A      = 8'd10;
    localparam logic [7:0] VEC_LINE_F      = 8'd11;
    localparam logic [7:0] VEC_PROTOCOL    = 8'd13;
    localparam logic [7:0] VEC_FORMAT_ERR  = 8'd14;
    localparam logic [7:0] VEC_SPURIOUS    = 8'd24;
    localparam logic [7:0] VEC_AUTO_LAST   = 8'd31;
    localparam logic [7:0] VEC_CP_FIRST    = 8'd48;
    localparam logic [7:0] VEC_CP_LAST     = 8'd54;
    localparam logic [7:0] VEC_MMU_CONFIG  = 8'd56;
    localparam logic [7:0] VEC_USER_FIRST  = 8'd64;
    localparam logic [7:0] VEC_USER_LAST   = 8'd255;

    localparam logic [3:0] FMT_FOUR_WORD = 4'd0;
    localparam logic [3:0] FMT_ALT_FOUR  = 4'd1;
    localparam logic [3:0] FMT_SIX_WORD  = 4'd2;
    localparam logic [3:0] FMT_CP_MID    = 4'd9;
    localparam logic [3:0] FMT_SHORT_BUS = 4'd10;
    localparam logic [3:0] FMT_LONG_BUS  = 4'd11;

    localparam logic [2:0] GRP_RESET     = 3'd0;
    localparam logic [2:0] GRP_BUS_FAULT = 3'd1;
    localparam logic [2:0] GRP_EXECUTION = 3'd2;
    localparam logic [2:0] GRP_PRE_INSTR = 3'd3;
    localparam logic [2:0] GRP_TRACE_INT = 3'd4;

    typedef struct packed {
        logic                    stacks_next;
        logic [FmtWordWidth-1:0] fmt_offset;
        logic [LengthWidth-1:0]  frame_length;
        logic [FormatWidth-1:0]  frame_format;
        logic [RankWidth-1:0]    priority_rank;
        logic [GroupWidth-1:0]   priority_group;
        logic [OffsetWidth-1:0]  table_offset;
    } evc_result_t;

    function automatic logic [GroupWidth+RankWidth-1:0] evc_priority(
        input logic [VectorWidth-1:0] v
    );
        logic [GroupWidth-1:0] grp;
        logic [RankWidth-1:0]  rank;
        grp  = GRP_EXECUTION;
        rank = 2'd0;
        case (v) inside
            VEC_RESET_SSP, VEC_RESET_PC: begin
                grp = GRP_RESET;
            end
            VEC_ADDR_ERROR: begin
                grp = GRP_BUS_FAULT;
            end
            VEC_BUS_ERROR: begin
                grp  = GRP_BUS_FAULT;
                rank = 2'd1;
            end
            VEC_ILLEGAL, VEC_LINE_A, VEC_LINE_F, VEC_PRIVILEGE,
            [VEC_CP_FIRST:VEC_CP_LAST]: begin
                grp = GRP_PRE_INSTR;
            end
            VEC_TRACE: begin
                grp  = GRP_TRACE_INT;
                rank = 2'd1;
            end
            [VEC_SPURIOUS:VEC_AUTO_LAST], [VEC_USER_FIRST:VEC_USER_LAST]: begin
                grp  = GRP_TRACE_INT;
                rank = 2'd2;
            end
            default: begin
                grp  = GRP_EXECUTION;
                rank = 2'd0;
            end
        endcase
        return {grp, rank};
    endfunction

    function automatic logic [FormatWidth-1:0] evc_format(
        input logic [VectorWidth-1:0] v
    );
        logic [FormatWidth-1:0] fmt;
        case (v) inside
            VEC_BUS_ERROR, VEC_ADDR_ERROR: fmt = FMT_SHORT_BUS;
            VEC_PROTOCOL:                  fmt = FMT_CP_MID;
            VEC_ZERO_DIV, VEC_CHK, VEC_TRAPCC, VEC_TRACE,
            VEC_MMU_CONFIG:                fmt = FMT_SIX_WORD;
            default:                       fmt = FMT_FOUR_WORD;
        endcase
        return fmt;
    endfunction

    function automatic logic [LengthWidth-1:0] evc_words(
        input logic [FormatWidth-1:0] fmt
    );
        logic [LengthWidth-1:0] words;
        case (fmt)
            FMT_FOUR_WORD, FMT_ALT_FOUR: words = 6'd4;
            FMT_SIX_WORD:                words = 6'd6;
            FMT_CP_MID:                  words = 6'd10;
            FMT_SHORT_BUS:               words = 6'd16;
            FMT_LONG_BUS:                words = 6'd46;
            default:                     words = 6'd0;
        endcase
        return words;
    endfunction

    function automatic logic evc_stacks_next(input logic [VectorWidth-1:0] v);
        logic nxt;
        case (v) inside
            VEC_ILLEGAL, VEC_LINE_A, VEC_LINE_F, VEC_PRIVILEGE, VEC_FORMAT_ERR,
            [VEC_CP_FIRST:VEC_CP_LAST]: nxt = 1'b0;
            default:                    nxt = 1'b1;
        endcase
        return nxt;
    endfunction

    function automatic evc_result_t evc_classify(input logic [VectorWidth-1:0] v);
        evc_result_t r;
        r.table_offset = {v, 2'b00};
        {r.priority_group, r.priority_rank} = evc_priority(v);
        r.frame_format = evc_format(v);
        r.frame_length = evc_words(r.frame_format);
        r.fmt_offset   = {r.frame_format, 2'b00, r.table_offset};
        r.stacks_next  = evc_stacks_next(v);
        return r;
    endfunction

endpackage

@@ rtl/exception_vector_classifier_top.sv @@
// Top level of the exception vector classifier: input register, decode and
// result register on stream channels. Depends on evc_pkg.
`timescale 1ns / 1ps

// Usage
// The slave channel takes one word per vector number in s_tdata[7:0]. The
// master channel returns one word per vector with the table offset, the
// priority group and rank, the stack frame format and length, the
// format/offset word and the stacked-PC flag.
// Each word passes an input register and then a result register; a result
// is offered from the result register once its vector has moved there from
// the input register. While m_tready stays high, one vector can be
// accepted in every cycle; throughput is one word per cycle, set by the
// single decode stage between the two registers.
// The stages advance as a pipeline: while the receiver holds m_tready low the
// result is held, one further word may wait in the input register, and
// s_tready then falls until the result is taken.
// Reset empties both stages; no result is pending afterwards.
module exception_vector_classifier_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // vector [7:0]
    input  logic [evc_pkg::InDataWidth-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // table_offset [9:0], priority_group [12:10], priority_rank [14:13],
    // frame_format [18:15], frame_length [24:19], fmt_offset [40:25],
    // stacks_next [41], zero fill [47:42]
    output logic [evc_pkg::OutDataWidth-1:0]    m_tdata
);
    import evc_pkg::*;

    localparam int ResultWidth = $bits(evc_result_t);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [VectorWidth-1:0] vector_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    evc_result_t            result_reg;
    evc_result_t            result_next;
    logic                   out_ready;
    logic                   in_ready;
    logic                   s_accept;

    assign out_ready = !out_valid_reg || m_tready;
    assign in_ready  = !in_valid_reg || out_ready;
    assign s_accept  = s_tvalid && in_ready;
    assign s_tready  = in_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_ready) begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (out_ready) begin
            out_valid_next = in_valid_reg;
        end
        result_next = evc_classify(vector_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            vector_reg <= s_tdata[VectorWidth-1:0];
        end
        if (out_ready && in_valid_reg) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutDataWidth-ResultWidth){1'b0}}, result_reg};

    // The format/offset word carries the frame format and the table offset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[40:37] == m_tdata[18:15]) &&
                     (m_tdata[36:25] == {2'b00, m_tdata[9:0]}))
        else $error("format word does not match format and offset");

    // Every result names a frame of known length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[24:19] != 6'd0))
        else $error("frame length of a result is zero");

    // A staged vector moves into the result register when that stage is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_ready) |=> m_tvalid)
        else $error("staged vector did not reach the result register");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

endmodule

@@ bench/exception_vector_classifier_top_test.sv @@
// Self-checking bench for exception_vector_classifier_top: every vector word sent is
// classified by a local decode, and each result word is compared field by field.
// Depends on evc_pkg and the exception_vector_classifier_top RTL.
`timescale 1ns / 1ps

module exception_vector_classifier_top_test;

    import evc_pkg::*;

    typedef struct packed {
        logic [VectorWidth-1:0] vec;
        evc_result_t            frame;
    } pending_frame_t;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [InDataWidth-1:0]  s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OutDataWidth-1:0] m_tdata;

    pending_frame_t pending_frames[$];
    int unsigned    mismatch_count;
    int unsigned    accepted_count;
    int unsigned    checked_count;
    int unsigned    input_stall_cycles;
    bit             vector_seen[256];
    bit             idling_on;
    int unsigned    hold_request;

    exception_vector_classifier_top i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic evc_result_t classify_vector(input logic [VectorWidth-1:0] vec);
        evc_result_t           r;
        logic [FormatWidth-1:0] fmt;
        r.table_offset   = OffsetWidth'(vec) << 2;
        r.priority_group = GRP_EXECUTION;
        r.priority_rank  = 2'd0;
        if (vec <= VEC_RESET_PC) begin
            r.priority_group = GRP_RESET;
        end else if (vec == VEC_ADDR_ERROR) begin
            r.priority_group = GRP_BUS_FAULT;
        end else if (vec == VEC_BUS_ERROR) begin
            r.priority_group = GRP_BUS_FAULT;
            r.priority_rank  = 2'd1;
        end else if (vec == VEC_ILLEGAL || vec == VEC_LINE_A || vec == VEC_LINE_F ||
                     vec == VEC_PRIVILEGE ||
                     (vec >= VEC_CP_FIRST && vec <= VEC_CP_LAST)) begin
            r.priority_group = GRP_PRE_INSTR;
        end else if (vec == VEC_TRACE) begin
            r.priority_group = GRP_TRACE_INT;
            r.priority_rank  = 2'd1;
        end else if ((vec >= VEC_SPURIOUS && vec <= VEC_AUTO_LAST) ||
                     vec >= VEC_USER_FIRST) begin
            r.priority_group = GRP_TRACE_INT;
            r.priority_rank  = 2'd2;
        end

        if (vec == VEC_BUS_ERROR || vec == VEC_ADDR_ERROR) begin
            fmt = FMT_SHORT_BUS;
        end else if (vec == VEC_PROTOCOL) begin
            fmt = FMT_CP_MID;
        end else if (vec == VEC_ZERO_DIV || vec == VEC_CHK || vec == VEC_TRAPCC ||
                     vec == VEC_TRACE || vec == VEC_MMU_CONFIG) begin
            fmt = FMT_SIX_WORD;
        end else begin
            fmt = FMT_FOUR_WORD;
        end
        r.frame_format = fmt;

        case (fmt)
            FMT_FOUR_WORD, FMT_ALT_FOUR: r.frame_length = 6'd4;
            FMT_SIX_WORD:                r.frame_length = 6'd6;
            FMT_CP_MID:                  r.frame_length = 6'd10;
            FMT_SHORT_BUS:               r.frame_length = 6'd16;
            FMT_LONG_BUS:                r.frame_length = 6'd46;
            default:                     r.frame_length = 6'd0;
        endcase

        r.fmt_offset  = {fmt, OffsetFieldWidth'(r.table_offset)};
        r.stacks_next = !(vec == VEC_ILLEGAL || vec == VEC_LINE_A || vec == VEC_LINE_F ||
                          vec == VEC_PRIVILEGE || vec == VEC_FORMAT_ERR ||
                          (vec >= VEC_CP_FIRST && vec <= VEC_CP_LAST));
        return r;
    endfunction

    function automatic void check_field(input string field_name, input logic [7:0] vec,
                                        input int unsigned want, input int unsigned got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("%0t: vector %0d, %s expected %0d, got %0d",
                         $realtime, vec, field_name, want, got);
            end
        end
    endfunction

    always @(posedge aclk) begin
        pending_frame_t exp_frame;
        evc_result_t    got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                exp_frame.vec   = s_tdata;
                exp_frame.frame = classify_vector(s_tdata);
                pending_frames.push_back(exp_frame);
                accepted_count++;
                vector_seen[s_tdata] = 1'b1;
            end
            if (s_tvalid && !s_tready) begin
                input_stall_cycles++;
            end
            if (m_tvalid && m_tready) begin
                if (pending_frames.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t: result word with nothing outstanding, tdata %h",
                                 $realtime, m_tdata);
                    end
                end else begin
                    exp_frame = pending_frames.pop_front();
                    got = m_tdata[$bits(evc_result_t)-1:0];
                    check_field("table_offset", exp_frame.vec,
                                32'(exp_frame.frame.table_offset), 32'(got.table_offset));
                    check_field("priority_group", exp_frame.vec,
                                32'(exp_frame.frame.priority_group),
                                32'(got.priority_group));
                    check_field("priority_rank", exp_frame.vec,
                                32'(exp_frame.frame.priority_rank), 32'(got.priority_rank));
                    check_field("frame_format", exp_frame.vec,
                                32'(exp_frame.frame.frame_format), 32'(got.frame_format));
                    check_field("frame_length", exp_frame.vec,
                                32'(exp_frame.frame.frame_length), 32'(got.frame_length));
                    check_field("fmt_offset", exp_frame.vec,
                                32'(exp_frame.frame.fmt_offset), 32'(got.fmt_offset));
                    check_field("stacks_next", exp_frame.vec,
                                32'(exp_frame.frame.stacks_next), 32'(got.stacks_next));
                    check_field("zero fill", exp_frame.vec, 0,
                                32'(m_tdata[OutDataWidth-1:$bits(evc_result_t)]));
                    checked_count++;
                end
            end
        end
    end

    // The receiver stalls at random, or holds off completely for a requested
    // number of cycles so that both pipeline stages fill and s_tready falls.
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 99) < 19) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_vector(input logic [VectorWidth-1:0] vec);
        while (idling_on && $urandom_range(0, 99) < 19) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= vec;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (pending_frames.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic test_directed_vectors();
        logic [VectorWidth-1:0] corner_vectors[$];
        corner_vectors = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9,
                           8'd10, 8'd11, 8'd12, 8'd13, 8'd14, 8'd24, 8'd31, 8'd47,
                           8'd48, 8'd54, 8'd55, 8'd56, 8'd64, 8'd255};
        foreach (corner_vectors[i]) begin
            send_vector(corner_vectors[i]);
        end
    endtask

    task automatic test_full_sweep();
        for (int v = 0; v < 256; v++) begin
            send_vector(VectorWidth'(v));
        end
    endtask

    task automatic test_backpressure();
        idling_on    = 1'b0;
        hold_request = 48;
        for (int i = 0; i < 16; i++) begin
            send_vector(VectorWidth'($urandom_range(0, 255)));
        end
        idling_on = 1'b1;
    endtask

    task automatic test_random_vectors(input int unsigned count);
        logic [VectorWidth-1:0] vec;
        for (int unsigned i = 0; i < count; i++) begin
            idling_on = !(i >= 600 && i < 900);
            if ($urandom_range(0, 1) != 0) begin
                vec = VectorWidth'($urandom_range(0, 63));
            end else begin
                vec = VectorWidth'($urandom_range(0, 255));
            end
            send_vector(vec);
        end
        idling_on = 1'b1;
    endtask

    initial begin
        int unsigned distinct;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        idling_on    = 1'b1;
        hold_request = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_vectors();
        test_full_sweep();
        test_backpressure();
        test_random_vectors(1500);
        wait_for_drain();
        repeat (6) @(posedge aclk);

        distinct = 0;
        foreach (vector_seen[i]) begin
            distinct += 32'(vector_seen[i]);
        end
        $display("Classified %0d vector words (%0d of 256 distinct), %0d results checked.",
                 accepted_count, distinct, checked_count);
        $display("Input held off for %0d cycles under receiver back-pressure.",
                 input_stall_cycles);
        if (mismatch_count == 0 && pending_frames.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d results outstanding.", pending_frames.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/evc_pkg.sv
rtl/exception_vector_classifier_top.sv
bench/exception_vector_classifier_top_test.sv
